/* sv/assert_macros.svh */
// Assertion macros shared by the RTL that carries concurrent checks.
// No dependencies; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising clock edge outside of reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/pwmc_pkg.sv */
// Shared types and constants of the two-channel pulse-width median capture.
// No dependencies; imported by every module of the block.
package pwmc_pkg;

    // Default window depth
    localparam int WINDOW_DEF = 15;

    // Field widths
    localparam int VAL_W  = 16;
    localparam int CIDX_W = 8;

    // Register indexes of the configuration port
    localparam logic [CIDX_W-1:0] CFG_TIMEOUT = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_MIN     = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX     = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_PERIOD  = 8'd3;

    // Reset values of the configuration registers
    localparam logic [VAL_W-1:0] TIMEOUT_RST = 16'd30000;
    localparam logic [VAL_W-1:0] MIN_RST     = 16'd1000;
    localparam logic [VAL_W-1:0] MAX_RST     = 16'd2000;
    localparam logic [VAL_W-1:0] PERIOD_RST  = 16'd1000;

    localparam logic [VAL_W-1:0] SAT_MAX = 16'hFFFF;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;   // accept a tick: edge tracking
        logic cond;   // condition widths, shift windows, restart scan
        logic scan;   // issue one rank-search candidate
        logic load;   // load the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;  // candidate counter at its final entry
        logic busy;       // rank-search pipeline still holds work
    } t_sts;

endpackage

/* sv/pwm_pulse_width_median_capture.sv */
// Top level of the two-channel pulse-width capture with median windows.
// Depends on pwmc_pkg, pwmc_ctrl, pwmc_datapath and assert_macros.svh.
//
// Usage: every input transaction on the s_axis channel is one microsecond
// tick carrying the two pin levels. Each channel measures the width of its
// last pulse, zeroes it after the timeout, clamps it, and every sample period
// shifts it into a WINDOW-deep window. Each input transaction yields exactly
// one m_axis transaction with the median of both windows.
// Configuration transactions on the cfg channel (always ready) set timeout,
// clamp limits and sample period; write them only while the block is idle.
// Sequencing: an accepted tick is tracked and conditioned, then the rank
// search visits one window entry a cycle through a three-stage compare and
// count pipeline, which drains before the result loads. A new tick is
// accepted in the cycle after the result loads, so the block takes no new
// tick until the previous result has loaded.
// Stall: the result sits in an output register; a new tick is accepted while
// it waits, but the next result loads only once the receiver has taken it.
// Reset: synchronous, active low; registers return to their defaults, all
// counts, widths and windows clear, no result is pending.
`include "assert_macros.svh"

module pwm_pulse_width_median_capture
    import pwmc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input ticks
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // [0] level_a, [1] level_b, [7:2] zero
    // Results
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [2*VAL_W-1:0]   o_m_axis_tdata,   // [15:0] median_a, [31:16] median_b
    // Configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CIDX_W-1:0]    i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    pwmc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    pwmc_datapath #(.WINDOW(WINDOW)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_level_a   (i_s_axis_tdata[0]),
        .i_level_b   (i_s_axis_tdata[1]),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_m_axis_tdata)
    );

    // Checks
    `ASSERT_AT(a_idle_not_busy, i_clk, i_rst_n, o_s_axis_tready |-> !w_sts.busy, "busy in idle")
    `ASSERT_AT(a_load_valid, i_clk, i_rst_n, w_cmd.load |=> o_m_axis_tvalid, "load not shown")
    `ASSERT_AT(a_cmd_onehot, i_clk, i_rst_n, $onehot0(w_cmd), "command overlap")
    `ASSERT_ALWAYS(a_rst_no_valid, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "valid after reset")

endmodule

/* sv/pwmc_chan.sv */
// One channel: edge tracking, width conditioning, median window and rank search.
// Depends on pwmc_pkg.
module pwmc_chan
    import pwmc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic                       i_level,
    input  logic                       i_shift,
    input  logic [$clog2(WINDOW)-1:0]  i_idx,
    input  logic [VAL_W-1:0]           i_timeout,
    input  logic [VAL_W-1:0]           i_min,
    input  logic [VAL_W-1:0]           i_max,
    output logic [VAL_W-1:0]           o_median,
    output logic                       o_busy
);

    localparam int NG = (WINDOW + 7) / 8;
    localparam int PW = NG * 8;
    localparam int LW = $clog2(PW + 1);
    localparam int K1 = (WINDOW - 1) / 2;
    localparam int K2 = WINDOW / 2;

    // Tracking state
    logic             r_last;
    logic [VAL_W-1:0] r_since;
    logic [VAL_W-1:0] r_width;
    logic [VAL_W-1:0] r_win [WINDOW];

    // Rank-search pipeline
    logic             r_pa, r_pb;
    logic [VAL_W-1:0] r_cand_a, r_cand_b;
    logic [WINDOW-1:0] r_lt, r_le;
    logic [3:0]       r_glt [NG];
    logic [3:0]       r_gle [NG];
    logic [VAL_W-1:0] r_m1, r_m2;

    logic             w_rise, w_fall;
    logic [VAL_W-1:0] n_since;
    logic [VAL_W-1:0] w_lo, w_clamp, n_cond;
    logic [VAL_W-1:0] w_cand;
    logic [PW-1:0]    w_lt_pad, w_le_pad;
    logic [3:0]       n_glt [NG];
    logic [3:0]       n_gle [NG];
    logic [LW-1:0]    w_lt_sum, w_le_sum;
    logic [VAL_W:0]   w_mid_sum;

    // Edge detection and saturating tick count
    always_comb begin
        w_rise  = !r_last && i_level;
        w_fall  = r_last && !i_level;
        if (w_rise) begin
            n_since = '0;
        end else if (r_since != SAT_MAX) begin
            n_since = r_since + VAL_W'(1);
        end else begin
            n_since = r_since;
        end
    end

    // Lower and upper clamp (upper wins), overridden by the timeout to zero
    always_comb begin
        w_lo    = (r_width < i_min) ? i_min : r_width;
        w_clamp = (w_lo > i_max) ? i_max : w_lo;
        n_cond  = (r_since > i_timeout) ? '0 : w_clamp;
    end

    assign w_cand = r_win[i_idx];

    // Group popcounts of the compare vectors
    always_comb begin
        w_lt_pad = '0;
        w_le_pad = '0;
        w_lt_pad[WINDOW-1:0] = r_lt;
        w_le_pad[WINDOW-1:0] = r_le;
        for (int g = 0; g < NG; g++) begin
            n_glt[g] = '0;
            n_gle[g] = '0;
            for (int b = 0; b < 8; b++) begin
                n_glt[g] = n_glt[g] + 4'(w_lt_pad[g*8+b]);
                n_gle[g] = n_gle[g] + 4'(w_le_pad[g*8+b]);
            end
        end
    end

    // Rank of the candidate from the group counts
    always_comb begin
        w_lt_sum = '0;
        w_le_sum = '0;
        for (int g = 0; g < NG; g++) begin
            w_lt_sum = w_lt_sum + LW'(r_glt[g]);
            w_le_sum = w_le_sum + LW'(r_gle[g]);
        end
    end

    // Control and tracking registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= 1'b0;
            r_since <= '0;
            r_width <= '0;
            r_pa    <= 1'b0;
            r_pb    <= 1'b0;
            for (int j = 0; j < WINDOW; j++) begin
                r_win[j] <= '0;
            end
        end else begin
            r_pa <= i_cmd.scan;
            r_pb <= r_pa;
            if (i_cmd.take) begin
                r_last  <= i_level;
                r_since <= n_since;
                if (w_fall) begin
                    r_width <= n_since;
                end
            end
            if (i_cmd.cond) begin
                r_width <= n_cond;
                if (i_shift) begin
                    for (int j = 0; j < WINDOW - 1; j++) begin
                        r_win[j] <= r_win[j+1];
                    end
                    r_win[WINDOW-1] <= n_cond;
                end
            end
        end
    end

    // Rank-search datapath: compare, count, select
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_cand_a <= w_cand;
            for (int j = 0; j < WINDOW; j++) begin
                r_lt[j] <= r_win[j] < w_cand;
                r_le[j] <= r_win[j] <= w_cand;
            end
        end
        if (r_pa) begin
            r_cand_b <= r_cand_a;
            for (int g = 0; g < NG; g++) begin
                r_glt[g] <= n_glt[g];
                r_gle[g] <= n_gle[g];
            end
        end
        if (r_pb) begin
            if (w_lt_sum <= LW'(K1) && LW'(K1) < w_le_sum) begin
                r_m1 <= r_cand_b;
            end
            if (w_lt_sum <= LW'(K2) && LW'(K2) < w_le_sum) begin
                r_m2 <= r_cand_b;
            end
        end
    end

    // Truncated mean of the middle pair (same value twice for odd depth)
    assign w_mid_sum = {1'b0, r_m1} + {1'b0, r_m2};
    assign o_median  = w_mid_sum[VAL_W:1];
    assign o_busy    = r_pa || r_pb;

endmodule

/* sv/pwmc_datapath.sv */
// Datapath: configuration registers, sample-period counter, both channels,
// candidate counter and output register. Depends on pwmc_pkg and pwmc_chan.
module pwmc_datapath
    import pwmc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_level_a,
    input  logic                  i_level_b,
    input  logic                  i_cfg_we,
    input  logic [CIDX_W-1:0]     i_cfg_index,
    input  logic [VAL_W-1:0]      i_cfg_data,
    output logic [2*VAL_W-1:0]    o_result
);

    localparam int IW = $clog2(WINDOW);

    logic [VAL_W-1:0]   r_timeout, r_min, r_max, r_period;
    logic [VAL_W-1:0]   r_pcount;
    logic [IW-1:0]      r_idx;
    logic [2*VAL_W-1:0] r_out;

    logic [VAL_W-1:0]   n_pcount;
    logic               w_shift;
    logic [VAL_W-1:0]   w_med_a, w_med_b;
    logic               w_busy_a, w_busy_b;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_min     <= MIN_RST;
            r_max     <= MAX_RST;
            r_period  <= PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_MIN:     r_min     <= i_cfg_data;
                CFG_MAX:     r_max     <= i_cfg_data;
                CFG_PERIOD:  r_period  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Saturating sample-period counter and shift decision
    always_comb begin
        n_pcount = (r_pcount != SAT_MAX) ? r_pcount + VAL_W'(1) : r_pcount;
        w_shift  = n_pcount >= r_period;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= '0;
            r_idx    <= '0;
        end else begin
            if (i_cmd.cond) begin
                r_pcount <= w_shift ? '0 : n_pcount;
                r_idx    <= '0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= {w_med_b, w_med_a};
        end
    end

    pwmc_chan #(.WINDOW(WINDOW)) u_chan_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_level   (i_level_a),
        .i_shift   (w_shift),
        .i_idx     (r_idx),
        .i_timeout (r_timeout),
        .i_min     (r_min),
        .i_max     (r_max),
        .o_median  (w_med_a),
        .o_busy    (w_busy_a)
    );

    pwmc_chan #(.WINDOW(WINDOW)) u_chan_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_level   (i_level_b),
        .i_shift   (w_shift),
        .i_idx     (r_idx),
        .i_timeout (r_timeout),
        .i_min     (r_min),
        .i_max     (r_max),
        .o_median  (w_med_b),
        .o_busy    (w_busy_b)
    );

    assign o_sts.scan_last = r_idx == IW'(WINDOW - 1);
    assign o_sts.busy      = w_busy_a || w_busy_b;
    assign o_result        = r_out;

endmodule

/* sv/pwmc_ctrl.sv */
// Controller state machine: sequences tracking, scan and output handshake.
// Depends on pwmc_pkg.
module pwmc_ctrl
    import pwmc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    output logic o_s_ready,
    output logic o_m_valid,
    input  logic i_m_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_COND  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid;

    // Commands
    always_comb begin
        o_cmd.take = (r_state == ST_IDLE) && i_s_valid;
        o_cmd.cond = r_state == ST_COND;
        o_cmd.scan = r_state == ST_SCAN;
        o_cmd.load = (r_state == ST_OUT) && (!r_m_valid || i_m_ready);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_s_valid) n_state = ST_COND;
            ST_COND:  n_state = ST_SCAN;
            ST_SCAN:  if (i_sts.scan_last) n_state = ST_DRAIN;
            ST_DRAIN: if (!i_sts.busy) n_state = ST_OUT;
            ST_OUT:   if (o_cmd.load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_s_ready = r_state == ST_IDLE;
    assign o_m_valid = r_m_valid;

endmodule

/* dv/pwm_pulse_width_median_capture_tb.sv */
// Self-checking bench for the two-channel pulse-width median capture block.
// Depends on pwmc_pkg and the pwm_pulse_width_median_capture RTL; runs standalone.
// Pin-level ticks are streamed in, medians are predicted per tick and compared.
module pwm_pulse_width_median_capture_tb;
    import pwmc_pkg::*;

    localparam int WINDOW = WINDOW_DEF;

    typedef struct packed {
        logic [VAL_W-1:0] med_b;
        logic [VAL_W-1:0] med_a;
    } t_medians;

    // DUT signals; the driven inputs are known from time zero
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [7:0]          i_s_axis_tdata = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [2*VAL_W-1:0]  o_m_axis_tdata;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index = '0;
    logic [VAL_W-1:0]    i_cfg_data = '0;

    // Ticks waiting to be sent ([0] level_a, [1] level_b) and medians still owed
    logic [1:0]  tick_q[$];
    t_medians    medians_due[$];

    // Predictor copy of registers and state
    logic [VAL_W-1:0] cfg_timeout = TIMEOUT_RST;
    logic [VAL_W-1:0] cfg_min     = MIN_RST;
    logic [VAL_W-1:0] cfg_max     = MAX_RST;
    logic [VAL_W-1:0] cfg_period  = PERIOD_RST;
    logic             pin_prev [2];
    logic [VAL_W-1:0] ticks_since_rise [2];
    logic [VAL_W-1:0] held_width [2];
    logic [VAL_W-1:0] shift_count;
    logic [VAL_W-1:0] width_win [2][WINDOW];

    // Idling control
    bit  calm = 1'b0;
    int  src_gap = 0;
    int  sink_hold = 0;
    int  sink_pick;
    t_medians want;

    // Pulse generator state
    logic gen_level [2];
    int   gen_run [2];

    int err_count = 0;

    pwm_pulse_width_median_capture #(
        .WINDOW(WINDOW)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        for (int c = 0; c < 2; c++) begin
            pin_prev[c] = 1'b0;
            ticks_since_rise[c] = '0;
            held_width[c] = '0;
            gen_level[c] = 1'b0;
            gen_run[c] = 0;
            for (int i = 0; i < WINDOW; i++) width_win[c][i] = '0;
        end
        shift_count = '0;
    end

    task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] exp_val);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $time);
        err_count++;
    endtask

    // Idle length: mostly none, some short, a few long
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Median of one channel's window; even depths take the truncated mean
    function automatic logic [VAL_W-1:0] window_median(input int ch);
        logic [VAL_W-1:0] s [WINDOW];
        logic [VAL_W-1:0] v;
        int j;
        for (int i = 0; i < WINDOW; i++) s[i] = width_win[ch][i];
        for (int i = 1; i < WINDOW; i++) begin
            v = s[i];
            j = i;
            while (j > 0 && s[j-1] > v) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = v;
        end
        if (WINDOW % 2 != 0) return s[WINDOW/2];
        return VAL_W'(({1'b0, s[WINDOW/2-1]} + {1'b0, s[WINDOW/2]}) >> 1);
    endfunction

    // One microsecond tick: edge tracking, conditioning, window shift, medians
    task automatic advance_tick(input logic [1:0] lv);
        t_medians m;
        for (int c = 0; c < 2; c++) begin
            if (!pin_prev[c] && lv[c]) begin
                ticks_since_rise[c] = '0;
            end else if (ticks_since_rise[c] != SAT_MAX) begin
                ticks_since_rise[c] = ticks_since_rise[c] + 1'b1;
            end
            if (pin_prev[c] && !lv[c]) held_width[c] = ticks_since_rise[c];
            pin_prev[c] = lv[c];
            if (ticks_since_rise[c] > cfg_timeout) begin
                held_width[c] = '0;
            end else begin
                if (held_width[c] < cfg_min) held_width[c] = cfg_min;
                if (held_width[c] > cfg_max) held_width[c] = cfg_max;
            end
        end
        if (shift_count != SAT_MAX) shift_count = shift_count + 1'b1;
        if (shift_count >= cfg_period) begin
            for (int c = 0; c < 2; c++) begin
                for (int i = 0; i + 1 < WINDOW; i++) width_win[c][i] = width_win[c][i+1];
                width_win[c][WINDOW-1] = held_width[c];
            end
            shift_count = '0;
        end
        m.med_a = window_median(0);
        m.med_b = window_median(1);
        medians_due.push_back(m);
    endtask

    // Tick driver: holds an offered transaction until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                advance_tick(tick_q.pop_front());
                src_gap = next_gap();
            end
            if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {6'd0, tick_q[0]};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (medians_due.size() == 0) begin
                    flag_mismatch("result with no tick pending", o_m_axis_tdata[15:0], '0);
                end else begin
                    want = medians_due.pop_front();
                    if (o_m_axis_tdata[15:0] !== want.med_a)
                        flag_mismatch("median_a", o_m_axis_tdata[15:0], want.med_a);
                    if (o_m_axis_tdata[31:16] !== want.med_b)
                        flag_mismatch("median_b", o_m_axis_tdata[31:16], want.med_b);
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                i_m_axis_tready <= 1'b0;
            end else begin
                sink_pick = next_gap();
                if (sink_pick > 0) begin
                    sink_hold = sink_pick - 1;
                    i_m_axis_tready <= 1'b0;
                end else begin
                    i_m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Register write; caller is aligned to a rising edge and lowers valid afterwards
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TIMEOUT: cfg_timeout = val;
            CFG_MIN:     cfg_min = val;
            CFG_MAX:     cfg_max = val;
            CFG_PERIOD:  cfg_period = val;
            default: ;
        endcase
    endtask

    // All four registers plus one write to an unused index
    task automatic set_config(input logic [VAL_W-1:0] tmo, input logic [VAL_W-1:0] mn,
                              input logic [VAL_W-1:0] mx, input logic [VAL_W-1:0] per);
        @(posedge i_clk);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_MIN, mn);
        write_reg(CFG_MAX, mx);
        write_reg(CFG_PERIOD, per);
        write_reg(CIDX_W'($urandom_range(CFG_PERIOD + 1, 255)), VAL_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] cfg_pick(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return SAT_MAX;
        return VAL_W'($urandom_range(lo, hi));
    endfunction

    // Bit i of each pattern is the pin level on tick i
    task automatic push_levels(input logic [31:0] a_bits, input logic [31:0] b_bits,
                               input int n);
        for (int i = 0; i < n; i++) tick_q.push_back({b_bits[i], a_bits[i]});
    endtask

    // PWM-like pulse trains with random widths, plus some noise ticks
    task automatic push_pwm(input int n);
        logic [1:0] lv;
        int r;
        for (int k = 0; k < n; k++) begin
            for (int c = 0; c < 2; c++) begin
                if (gen_run[c] == 0) begin
                    gen_level[c] = !gen_level[c];
                    r = $urandom_range(0, 99);
                    if (r < 70) gen_run[c] = $urandom_range(1, 25);
                    else if (r < 90) gen_run[c] = $urandom_range(30, 90);
                    else gen_run[c] = 1;
                end
                gen_run[c]--;
                lv[c] = gen_level[c];
            end
            if ($urandom_range(0, 99) < 8) lv = 2'($urandom);
            tick_q.push_back(lv);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (tick_q.size() != 0 || medians_due.size() != 0) @(negedge i_clk);
    endtask

    // Stimulus sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Defaults: both pins high on the very first tick
        push_levels(32'b0101, 32'b0011, 4);
        wait_drained();

        // Shift every tick; short pulse clamped up, long pulse times out
        set_config(16'd6, 16'd2, 16'd5, 16'd0);
        @(negedge i_clk);
        push_levels(32'b00000000100111, 32'b00001111111111, 14);
        wait_drained();

        // Zero timeout, lower clamp above upper clamp
        set_config(16'd0, 16'd9, 16'd4, 16'd1);
        @(negedge i_clk);
        push_levels(32'b010101, 32'b110011, 6);
        wait_drained();

        // Random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0)
                set_config(SAT_MAX, 16'd0, SAT_MAX, SAT_MAX);
            else if (ph == 1)
                set_config(16'd1, SAT_MAX, 16'd0, 16'd1);
            else
                set_config(cfg_pick(1, 60), cfg_pick(0, 12), cfg_pick(4, 30), cfg_pick(0, 5));
            @(negedge i_clk);
            calm = (ph == 2);
            push_pwm(110);
            // Long receiver hold-off so the block backs up into its input
            if (ph == 3) sink_hold = 400;
            wait_drained();
        end
        calm = 1'b0;

        // Long steady levels under a large timeout: channel a low, channel b high
        set_config(16'd65534, 16'd100, 16'd5000, 16'd1);
        @(negedge i_clk);
        calm = 1'b1;
        push_levels(32'h001F_FFFF, 32'hFFFF_FFFF, 24);
        for (int i = 0; i < 60; i++) tick_q.push_back(2'b10);
        wait_drained();
        calm = 1'b0;

        repeat (WINDOW + 10) @(posedge i_clk);
        if (medians_due.size() != 0) flag_mismatch("medians never delivered", '0, '0);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* pwm_pulse_width_median_capture.f */
+incdir+sv
sv/pwmc_pkg.sv
sv/pwmc_chan.sv
sv/pwmc_datapath.sv
sv/pwmc_ctrl.sv
sv/pwm_pulse_width_median_capture.sv
dv/pwm_pulse_width_median_capture_tb.sv
